### src/occupancy_grid_ray_update_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the occupancy grid ray update unit
// Each macro expects signals named clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_ASSERT_SVH

// The property must hold at every edge outside reset.
`define OGRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the cycle after.
`define OGRU_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### src/ogru_pkg.sv
// ---------------------------------------------------------------------------
// ogru_pkg
// Shared types and constants of the occupancy grid ray update unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ogru_pkg;

  localparam int GRID_DIM_DEFAULT = 256;

  localparam int COORD_W  = 11;
  localparam int CODE_W   = 8;
  localparam int COUNT_W  = 10;
  localparam int CFG_IDX_W = 3;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HIT_PROB     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PROB    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NO_INFO_CODE = 3'd4;

  localparam logic [CODE_W-1:0] HIT_PROB_RESET     = 8'd179;
  localparam logic [CODE_W-1:0] MISS_PROB_RESET    = 8'd102;
  localparam logic [CODE_W-1:0] PROB_FLOOR_RESET   = 8'd3;
  localparam logic [CODE_W-1:0] PROB_CEILING_RESET = 8'd252;
  localparam logic [CODE_W-1:0] NO_INFO_CODE_RESET = 8'd127;

  // Operation codes of a request.
  localparam logic OP_RAY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Fixed-point update: dividend = 510*num + den, divisor = 2*den.
  localparam int DIVIDEND_W = 26;
  localparam int DIVISOR_W  = 18;
  localparam int QUOT_W     = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    CMD_RAY,
    CMD_READ,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COORD_W-1:0] robot_x;
    logic [COORD_W-1:0] robot_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } cmd_t;

endpackage

`default_nettype wire

### src/occupancy_grid_ray_update_unit.sv
// ---------------------------------------------------------------------------
// occupancy_grid_ray_update_unit
// Occupancy grid with Bayesian cell updates along a Bresenham ray.
// ---------------------------------------------------------------------------
//   Channel   Dir  Payload
//   s_*       in   tuser: operation; tdata: robot_x, robot_y, end_x, end_y
//   m_*       out  tuser: status;    tdata: cell_value, cells_updated
//   cfg_*     in   register index and 8-bit write data, no read-back
//
// After reset a clearing pass writes every grid cell; no request is accepted
// meanwhile. A read passes the read and read-data states before the finish state
// loads its result; a rejected request goes straight from idle to the finish
// state. Each cell update of a ray is a memory read-modify-write that waits on
// the bit-serial divider, and each walk cell also passes through the walk state.
// A two-entry command queue and the result register let either side stall.
// ---------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_ray_update_unit #(
  parameter int GRID_DIM = ogru_pkg::GRID_DIM_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // robot_x [10:0], robot_y [21:11], end_x [32:22], end_y [43:33], zero fill
  input  wire logic [ogru_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  wire logic                             s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // cell_value [7:0], cells_updated [17:8], zero fill
  output logic      [ogru_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic                                  m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [ogru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ogru_pkg::CODE_W-1:0]      cfg_wdata
);
  import ogru_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  logic clear_busy;

  ogru_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .clear_busy (clear_busy),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop)
  );

  ogru_back #(
    .GRID_DIM (GRID_DIM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .clear_busy (clear_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

### src/ogru_ram.sv
// ---------------------------------------------------------------------------
// ogru_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ogru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/ogru_div.sv
// ---------------------------------------------------------------------------
// ogru_div
// Restoring divider, one quotient bit per cycle, for a quotient below 512.
// ---------------------------------------------------------------------------
`default_nettype none

module ogru_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [ogru_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [ogru_pkg::DIVISOR_W-1:0]    divisor,
  output logic      [ogru_pkg::QUOT_W-1:0]       quotient,
  output logic                                   done
);
  import ogru_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [QUOT_W-1:0]    shreg;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W+1:0] trial;

  // The upper dividend bits are already below the divisor because the quotient
  // fits in QUOT_W bits, so only the low QUOT_W bits need a step each.
  always_comb begin
    trial = {1'b0, rem, shreg[QUOT_W-1]} - {2'b00, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        rem   <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
        shreg <= dividend[QUOT_W-1:0];
        cnt   <= CNT_W'(QUOT_W);
        busy  <= 1'b1;
      end else if (busy) begin
        if (!trial[DIVISOR_W+1]) begin
          rem   <= trial[DIVISOR_W-1:0];
          shreg <= {shreg[QUOT_W-2:0], 1'b1};
        end else begin
          rem   <= {rem[DIVISOR_W-2:0], shreg[QUOT_W-1]};
          shreg <= {shreg[QUOT_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = shreg;

endmodule

`default_nettype wire

### src/ogru_front.sv
// ---------------------------------------------------------------------------
// ogru_front
// Accepts requests, checks their coordinates and queues classified commands.
// ---------------------------------------------------------------------------
`default_nettype none

module ogru_front #(
  parameter int GRID_DIM = ogru_pkg::GRID_DIM_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [ogru_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic                             s_tuser,
  input  wire logic                             clear_busy,
  output ogru_pkg::cmd_t                        cmd,
  output logic                                  cmd_valid,
  input  wire logic                             cmd_pop
);
  import ogru_pkg::*;

  `include "occupancy_grid_ray_update_unit_assert.svh"

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_cnt;
  logic              push;
  cmd_t              incoming;
  logic              robot_ok;
  logic              end_ok;

  function automatic logic in_grid(input logic [COORD_W-1:0] v);
    in_grid = !v[COORD_W-1] && (v < COORD_W'(GRID_DIM));
  endfunction

  always_comb begin
    incoming.robot_x = s_tdata[COORD_W-1:0];
    incoming.robot_y = s_tdata[2*COORD_W-1:COORD_W];
    incoming.end_x   = s_tdata[3*COORD_W-1:2*COORD_W];
    incoming.end_y   = s_tdata[4*COORD_W-1:3*COORD_W];
    robot_ok = in_grid(incoming.robot_x) && in_grid(incoming.robot_y);
    end_ok   = in_grid(incoming.end_x) && in_grid(incoming.end_y);
    if (s_tuser == OP_READ) begin
      incoming.kind = end_ok ? CMD_READ : CMD_REJECT;
    end else begin
      incoming.kind = (end_ok && robot_ok) ? CMD_RAY : CMD_REJECT;
    end
  end

  assign s_tready  = (q_cnt != QCNT_W'(QUEUE_DEPTH)) && !clear_busy;
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (q_cnt != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !cmd_pop) begin
        q_cnt <= q_cnt + QCNT_W'(1);
      end else if (cmd_pop && !push) begin
        q_cnt <= q_cnt - QCNT_W'(1);
      end
    end
  end

  `OGRU_ASSERT(a_cnt_bound, q_cnt <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `OGRU_ASSERT(a_pop_nonempty, !cmd_pop || cmd_valid, "command taken from empty queue")
  `OGRU_ASSERT_NEXT(a_push_grows, push && !cmd_pop, q_cnt == $past(q_cnt) + QCNT_W'(1),
                    "queue count did not grow on push")

endmodule

`default_nettype wire

### src/ogru_back.sv
// ---------------------------------------------------------------------------
// ogru_back
// Executes commands: grid clearing, cell reads, Bayesian cell updates and the
// line walk, and holds the result register and configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module ogru_back #(
  parameter int GRID_DIM = ogru_pkg::GRID_DIM_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ogru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ogru_pkg::CODE_W-1:0]      cfg_wdata,
  input  wire ogru_pkg::cmd_t                   cmd,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_pop,
  output logic                                  clear_busy,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [ogru_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                                  m_tuser
);
  import ogru_pkg::*;

  `include "occupancy_grid_ray_update_unit_assert.svh"

  localparam int CW    = $clog2(GRID_DIM);
  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = CW + 3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_DATA,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_SCL,
    S_UPD_DIV,
    S_UPD_WR,
    S_WALK,
    S_FIN
  } state_t;

  state_t state;

  logic [CODE_W-1:0] hit_prob, miss_prob, prob_floor, prob_ceiling, no_info_code;

  // Command and walk registers.
  logic [AW-1:0]        cur_addr;
  logic [CW-1:0]        rx, ry, ex, ey;
  logic [CW-1:0]        walk_x, walk_y, last;
  logic signed [EW-1:0] walk_error, inc_a, inc_b;
  logic                 x_major, step_pos, use_hit;
  logic [COUNT_W-1:0]   cnt;
  logic                 fin_status;
  logic [CODE_W-1:0]    fin_value;

  // Update datapath registers.
  logic [CODE_W-1:0]   prior;
  logic [2*CODE_W-1:0] prod_a, prod_b;
  logic                den_zero;

  // Result register.
  logic                res_status;
  logic [CODE_W-1:0]   res_value;
  logic [COUNT_W-1:0]  res_count;

  // RAM and divider.
  logic                  ram_we;
  logic [CODE_W-1:0]     ram_wdata, ram_rdata;
  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;
  logic [QUOT_W-1:0]     div_q;

  // Combinational helpers.
  logic [CW-1:0]        c_rx, c_ry, c_ex, c_ey;
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        adx, ady;
  logic                 s_x_major, s_step_pos;
  logic [CW-1:0]        s_wx, s_wy, s_last;
  logic signed [EW-1:0] s_err, s_inc_a, s_inc_b;
  logic [CODE_W-1:0]    u_code, prior_c;
  logic [DIVISOR_W-2:0] den;
  logic [CW-1:0]        major_cur, step_d, wx_n, wy_n;
  logic                 walk_more, minor_step, hit_end;
  logic signed [EW-1:0] err_n;
  logic [QUOT_W-1:0]    q_raw;
  logic [CODE_W-1:0]    q_ceil, q_new;
  logic                 out_free;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    cell_addr = AW'(AW'(x) * AW'(GRID_DIM)) + AW'(y);
  endfunction

  always_comb begin
    // Walk setup from the command at the head of the queue.
    c_rx = cmd.robot_x[CW-1:0];
    c_ry = cmd.robot_y[CW-1:0];
    c_ex = cmd.end_x[CW-1:0];
    c_ey = cmd.end_y[CW-1:0];
    dx   = $signed({1'b0, c_ex}) - $signed({1'b0, c_rx});
    dy   = $signed({1'b0, c_ey}) - $signed({1'b0, c_ry});
    adx  = dx[CW] ? CW'(-dx) : CW'(dx);
    ady  = dy[CW] ? CW'(-dy) : CW'(dy);
    s_x_major  = (ady <= adx);
    s_step_pos = (dx[CW] && dy[CW]) || (!dx[CW] && dx != '0 && !dy[CW] && dy != '0);
    if (s_x_major) begin
      s_err   = $signed({2'b00, ady, 1'b0}) - $signed({3'b000, adx});
      s_inc_a = $signed({2'b00, ady, 1'b0});
      s_inc_b = $signed({2'b00, ady, 1'b0}) - $signed({2'b00, adx, 1'b0});
      if (!dx[CW]) begin
        s_wx = c_rx; s_wy = c_ry; s_last = c_ex;
      end else begin
        s_wx = c_ex; s_wy = c_ey; s_last = c_rx;
      end
    end else begin
      s_err   = $signed({2'b00, adx, 1'b0}) - $signed({3'b000, ady});
      s_inc_a = $signed({2'b00, adx, 1'b0});
      s_inc_b = $signed({2'b00, adx, 1'b0}) - $signed({2'b00, ady, 1'b0});
      if (!dy[CW]) begin
        s_wx = c_rx; s_wy = c_ry; s_last = c_ey;
      end else begin
        s_wx = c_ex; s_wy = c_ey; s_last = c_ry;
      end
    end

    // One walk step.
    major_cur  = x_major ? walk_x : walk_y;
    walk_more  = (major_cur < last);
    minor_step = x_major ? !walk_error[EW-1]
                         : (!walk_error[EW-1] && walk_error != '0);
    step_d     = step_pos ? CW'(1) : '1;
    err_n      = minor_step ? walk_error + inc_b : walk_error + inc_a;
    if (x_major) begin
      wx_n = walk_x + CW'(1);
      wy_n = minor_step ? walk_y + step_d : walk_y;
    end else begin
      wx_n = minor_step ? walk_x + step_d : walk_x;
      wy_n = walk_y + CW'(1);
    end
    hit_end = (wx_n == ex) && (wy_n == ey);

    // Cell update arithmetic. Stored code 0 means no information yet.
    u_code  = use_hit ? hit_prob : miss_prob;
    prior_c = (ram_rdata == '0) ? no_info_code : ram_rdata;
    den     = {1'b0, prod_a} + {1'b0, prod_b};
    dividend = {1'b0, prod_a, 9'b0} - {9'b0, prod_a, 1'b0} + {9'b0, den};
    divisor  = {den, 1'b0};
    div_start = (state == S_UPD_SCL);

    q_raw  = den_zero ? {1'b0, prior} : div_q;
    q_ceil = (q_raw > {1'b0, prob_ceiling}) ? prob_ceiling : q_raw[CODE_W-1:0];
    q_new  = (q_ceil < prob_floor) ? prob_floor : q_ceil;

    ram_we    = (state == S_CLEAR) || (state == S_UPD_WR);
    ram_wdata = (state == S_CLEAR) ? '0 : q_new;

    out_free = !m_tvalid || m_tready;
  end

  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign clear_busy = (state == S_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_prob     <= HIT_PROB_RESET;
      miss_prob    <= MISS_PROB_RESET;
      prob_floor   <= PROB_FLOOR_RESET;
      prob_ceiling <= PROB_CEILING_RESET;
      no_info_code <= NO_INFO_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIT_PROB:     hit_prob     <= cfg_wdata;
        REG_MISS_PROB:    miss_prob    <= cfg_wdata;
        REG_PROB_FLOOR:   prob_floor   <= cfg_wdata;
        REG_PROB_CEILING: prob_ceiling <= cfg_wdata;
        REG_NO_INFO_CODE: no_info_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cur_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In the finish state the result register reloads m_tvalid itself.
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cur_addr <= cur_addr + AW'(1);
          if (cur_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            fin_status <= (cmd.kind == CMD_REJECT);
            fin_value  <= '0;
            cnt        <= '0;
            rx         <= c_rx;
            ry         <= c_ry;
            ex         <= c_ex;
            ey         <= c_ey;
            walk_x     <= s_wx;
            walk_y     <= s_wy;
            last       <= s_last;
            walk_error <= s_err;
            inc_a      <= s_inc_a;
            inc_b      <= s_inc_b;
            x_major    <= s_x_major;
            step_pos   <= s_step_pos;
            use_hit    <= 1'b1;
            cur_addr   <= cell_addr(c_ex, c_ey);
            unique case (cmd.kind)
              CMD_READ: state <= S_READ;
              CMD_RAY:  state <= S_UPD_RD;
              default:  state <= S_FIN;
            endcase
          end
        end
        S_READ: state <= S_READ_DATA;
        S_READ_DATA: begin
          fin_value <= ram_rdata;
          state     <= S_FIN;
        end
        S_UPD_RD: state <= S_UPD_MUL;
        S_UPD_MUL: begin
          prior  <= prior_c;
          prod_a <= 16'(prior_c) * 16'(u_code);
          prod_b <= 16'(8'd255 - prior_c) * 16'(8'd255 - u_code);
          state  <= S_UPD_SCL;
        end
        S_UPD_SCL: begin
          den_zero <= (den == '0);
          state    <= S_UPD_DIV;
        end
        S_UPD_DIV: begin
          if (div_done) begin
            state <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          cnt <= cnt + COUNT_W'(1);
          if (use_hit) begin
            use_hit  <= 1'b0;
            cur_addr <= cell_addr(rx, ry);
            state    <= S_UPD_RD;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_more) begin
            walk_x     <= wx_n;
            walk_y     <= wy_n;
            walk_error <= err_n;
            cur_addr   <= cell_addr(wx_n, wy_n);
            state      <= hit_end ? S_FIN : S_UPD_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            res_status <= fin_status;
            res_value  <= fin_value;
            res_count  <= cnt;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {{(M_TDATA_W - CODE_W - COUNT_W){1'b0}}, res_count, res_value};

  ogru_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr),
    .wdata (ram_wdata),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  ogru_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  `OGRU_ASSERT(a_div_in_wait, !div_done || state == S_UPD_DIV, "divider finished outside wait")
  `OGRU_ASSERT(a_no_result_clear, state != S_CLEAR || !m_tvalid, "result during clearing pass")
  `OGRU_ASSERT_NEXT(a_fin_loads, state == S_FIN && out_free, m_tvalid && state == S_IDLE,
                    "result register not loaded at finish")

endmodule

`default_nettype wire

### test/tb_occupancy_grid_ray_update_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_occupancy_grid_ray_update_unit
// Drives cast-ray and read requests into the occupancy grid unit under
// several register settings and random stalls on both streams. A local model
// of the grid predicts every result, and the results are checked in order.
// ---------------------------------------------------------------------------

class RayScoreboard;
  localparam int GRID = ogru_pkg::GRID_DIM_DEFAULT;

  byte unsigned grid_codes [GRID*GRID];
  int unsigned  hit_code, miss_code, floor_code, ceil_code, prior_code;
  logic [18:0]  pending [$];   // {status, cells_updated, cell_value}
  int           errors;

  function new();
    foreach (grid_codes[i]) grid_codes[i] = 0;
    hit_code   = ogru_pkg::HIT_PROB_RESET;
    miss_code  = ogru_pkg::MISS_PROB_RESET;
    floor_code = ogru_pkg::PROB_FLOOR_RESET;
    ceil_code  = ogru_pkg::PROB_CEILING_RESET;
    prior_code = ogru_pkg::NO_INFO_CODE_RESET;
    errors     = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      ogru_pkg::REG_HIT_PROB:     hit_code   = val;
      ogru_pkg::REG_MISS_PROB:    miss_code  = val;
      ogru_pkg::REG_PROB_FLOOR:   floor_code = val;
      ogru_pkg::REG_PROB_CEILING: ceil_code  = val;
      ogru_pkg::REG_NO_INFO_CODE: prior_code = val;
      default: ;
    endcase
  endfunction

  function bit on_grid(int x, int y);
    return x >= 0 && x < GRID && y >= 0 && y < GRID;
  endfunction

  // Bayesian merge of the cell's prior with u, rounded half up and clamped.
  function int unsigned merge_cell(int x, int y, int unsigned u);
    int unsigned c, num, den, q;
    if (!on_grid(x, y)) return 0;
    c = grid_codes[x*GRID + y];
    if (c == 0) c = prior_code;
    num = c * u;
    den = num + (255 - c) * (255 - u);
    if (den == 0) q = c;
    else q = (510 * num + den) / (2 * den);
    if (q > ceil_code) q = ceil_code;
    if (q < floor_code) q = floor_code;
    grid_codes[x*GRID + y] = q[7:0];
    return 1;
  endfunction

  function int unsigned trace_free_cells(int x1, int y1, int x2, int y2);
    int dx, dy, adx, ady, step, last, wx, wy, err;
    int unsigned n;
    dx = x2 - x1;  dy = y2 - y1;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
    n = 0;
    if (ady <= adx) begin
      err = 2*ady - adx;
      if (dx >= 0) begin wx = x1; wy = y1; last = x2; end
      else begin wx = x2; wy = y2; last = x1; end
      while (wx < last) begin
        wx++;
        if (err < 0) err += 2*ady;
        else begin wy += step; err += 2*(ady - adx); end
        if (wx == x2 && wy == y2) break;
        n += merge_cell(wx, wy, miss_code);
      end
    end else begin
      err = 2*adx - ady;
      if (dy >= 0) begin wx = x1; wy = y1; last = y2; end
      else begin wx = x2; wy = y2; last = y1; end
      while (wy < last) begin
        wy++;
        if (err <= 0) err += 2*adx;
        else begin wx += step; err += 2*(adx - ady); end
        if (wx == x2 && wy == y2) break;
        n += merge_cell(wx, wy, miss_code);
      end
    end
    return n;
  endfunction

  function void note_request(logic op, int rx, int ry, int ex, int ey);
    logic        status;
    logic [7:0]  value;
    int unsigned count;
    status = 1'b0; value = 8'd0; count = 0;
    if (op == ogru_pkg::OP_READ) begin
      if (!on_grid(ex, ey)) status = 1'b1;
      else value = grid_codes[ex*GRID + ey];
    end else if (!on_grid(rx, ry) || !on_grid(ex, ey)) begin
      status = 1'b1;
    end else begin
      count += merge_cell(ex, ey, hit_code);
      count += merge_cell(rx, ry, miss_code);
      count += trace_free_cells(rx, ry, ex, ey);
    end
    pending.insert(pending.size(), {status, count[9:0], value});
  endfunction

  function void check_result(logic status, logic [23:0] data);
    logic [18:0] want;
    if (pending.size() == 0) begin
      $display("%0t: result with none pending: status %0d value %0d count %0d",
               $time, status, data[7:0], data[17:8]);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (status !== want[18]) begin
      $display("%0t: status expected %0d actual %0d", $time, want[18], status);
      errors++;
    end
    if (data[7:0] !== want[7:0]) begin
      $display("%0t: cell_value expected %0d actual %0d", $time, want[7:0], data[7:0]);
      errors++;
    end
    if (data[17:8] !== want[17:8]) begin
      $display("%0t: cells_updated expected %0d actual %0d", $time, want[17:8], data[17:8]);
      errors++;
    end
  endfunction
endclass

module tb_occupancy_grid_ray_update_unit;
  import ogru_pkg::*;

  localparam int GRID = GRID_DIM_DEFAULT;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0] cfg_wdata = '0;

  RayScoreboard grid_model = new();
  int cycles = 0;
  bit steady = 0;   // no gaps on either side while set
  int last_x = 0, last_y = 0;

  occupancy_grid_ray_update_unit DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function int pick_gap();
    if (steady) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 5);
    return $urandom_range(2, 0);
  endfunction

  // Result side: random stalls, checked at the edge where the result moves.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) grid_model.check_result(m_tuser, m_tdata);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic op, int rx, int ry, int ex, int ey);
    int gap;
    logic [10:0] rxb, ryb, exb, eyb;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    rxb = 11'(rx); ryb = 11'(ry); exb = 11'(ex); eyb = 11'(ey);
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {4'b0, eyb, exb, ryb, rxb};
    do @(posedge clk); while (!s_tready);
    grid_model.note_request(op, int'($signed(rxb)), int'($signed(ryb)),
                            int'($signed(exb)), int'($signed(eyb)));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    grid_model.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_all(int hit, int miss, int flo, int ceil, int prior);
    write_reg(REG_HIT_PROB, 8'(hit));
    write_reg(REG_MISS_PROB, 8'(miss));
    write_reg(REG_PROB_FLOOR, 8'(flo));
    write_reg(REG_PROB_CEILING, 8'(ceil));
    write_reg(REG_NO_INFO_CODE, 8'(prior));
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (grid_model.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Mostly short rays inside the grid, some long ones, some raw coordinates,
  // and reads that often land where a recent ray went.
  task automatic random_item();
    int kind, rx, ry, ex, ey;
    kind = $urandom_range(99, 0);
    rx = $urandom_range(GRID-1, 0);
    ry = $urandom_range(GRID-1, 0);
    ex = rx + $urandom_range(40, 0) - 20;
    ey = ry + $urandom_range(40, 0) - 20;
    if (ex < 0) ex = 0;
    if (ex > GRID-1) ex = GRID-1;
    if (ey < 0) ey = 0;
    if (ey > GRID-1) ey = GRID-1;
    if (kind < 55) begin
      send_request(OP_RAY, rx, ry, ex, ey);
      last_x = ex; last_y = ey;
    end else if (kind < 63) begin
      send_request(OP_RAY, rx, ry, $urandom_range(GRID-1, 0), $urandom_range(GRID-1, 0));
    end else if (kind < 73) begin
      send_request(1'($urandom_range(1, 0)), $urandom_range(2047, 0), $urandom_range(2047, 0),
                   $urandom_range(2047, 0), $urandom_range(2047, 0));
    end else if (kind < 90) begin
      send_request(OP_READ, $urandom_range(2047, 0), $urandom_range(2047, 0),
                   last_x + $urandom_range(2, 0) - 1, last_y + $urandom_range(2, 0) - 1);
    end else begin
      send_request(OP_READ, rx, ry, ex, ey);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed requests at the reset settings.
    send_request(OP_READ, 0, 0, 0, 0);
    send_request(OP_RAY, 0, 0, GRID-1, GRID-1);
    send_request(OP_RAY, GRID-1, 0, 0, GRID-1);
    send_request(OP_RAY, 10, 10, 10, 10);
    send_request(OP_RAY, 50, 40, 20, 35);
    send_request(OP_RAY, 50, 40, 45, 10);
    send_request(OP_RAY, 60, 60, 70, 90);
    send_request(OP_RAY, 60, 60, 90, 50);
    send_request(OP_RAY, 100, 5, 100, 30);
    send_request(OP_RAY, 5, 100, 30, 100);
    send_request(OP_RAY, -1, 5, 5, 5);
    send_request(OP_RAY, 5, 5, GRID, 5);
    send_request(OP_RAY, -1024, 1023, 1023, -1024);
    send_request(OP_READ, 0, 0, -1, 0);
    send_request(OP_READ, 0, 0, 0, GRID);
    send_request(OP_READ, 0, 0, GRID-1, GRID-1);
    send_request(OP_READ, 0, 0, 10, 10);
    send_request(OP_READ, 0, 0, 40, 37);
    drain();

    // Writes beyond the register list must be ignored.
    write_reg(3'd5, 8'd1);
    write_reg(3'd7, 8'd255);
    repeat (20) random_item();
    drain();

    set_all(254, 1, 1, 254, 1);
    steady = 1;
    repeat (20) random_item();
    steady = 0;
    drain();

    // Floor above ceiling.
    set_all(1, 254, 254, 1, 254);
    repeat (20) random_item();
    drain();

    // Codes that can zero the divisor.
    set_all(255, 0, 0, 255, 0);
    send_request(OP_RAY, 200, 200, 200, 200);
    send_request(OP_READ, 0, 0, 200, 200);
    repeat (18) random_item();
    drain();

    repeat (3) begin
      set_all($urandom_range(254, 1), $urandom_range(254, 1), $urandom_range(30, 1),
              $urandom_range(254, 220), $urandom_range(254, 1));
      repeat (14) random_item();
      drain();
    end

    repeat (60) @(posedge clk);
    if (grid_model.errors == 0 && grid_model.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
